[design/lr_pkg.sv]
// Shared types and constants for the line rasterizer.
package lr_pkg;

   // Fixed field widths.
   localparam int SIZE_BITS     = 13;
   localparam int BPP_BITS      = 3;
   localparam int ADDR_BITS     = 32;
   localparam int COLOR_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   // Register values after reset.
   localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = 13'd480;
   localparam logic [BPP_BITS-1:0]   BPP_RESET    = 3'd4;
   localparam logic [ADDR_BITS-1:0]  BASE_RESET   = 32'd0;

   // The one pixel size that is not treated as four bytes.
   localparam logic [BPP_BITS-1:0]   BPP_THREE    = 3'd3;
   localparam logic [COLOR_BITS-1:0] COLOR_24_MASK = 32'h00FF_FFFF;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCREEN_WIDTH    = 2'd0,
      CSR_SCREEN_HEIGHT   = 2'd1,
      CSR_BYTES_PER_PIXEL = 2'd2,
      CSR_BUFFER_BASE     = 2'd3
   } csr_idx_type;

   // Request kinds.
   typedef enum logic {
      KIND_START   = 1'b0,
      KIND_ADVANCE = 1'b1
   } kind_type;

   // Control bits that travel with a pixel down the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } pix_ctl_type;

endpackage

[design/lr_if.sv]
// Channel interfaces for the line rasterizer: request, pixel result and register writes.
interface lr_req_if #(parameter int COORD_BITS = 12);
   import lr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0] line_color;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface lr_rsp_if #(parameter int COORD_BITS = 12);
   import lr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [ADDR_BITS-1:0]  pixel_address;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  last;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                   output ready);
endinterface

interface lr_csr_if;
   import lr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/lr_step.sv]
// Setup, Bresenham stepping, line state; a start or mid-line advance registers a pixel.
module lr_step #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_take,
   input  logic                          item_kind,
   input  logic [COORD_BITS-1:0]         start_x,
   input  logic [COORD_BITS-1:0]         start_y,
   input  logic [COORD_BITS-1:0]         end_x,
   input  logic [COORD_BITS-1:0]         end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0] line_color,
   input  logic [lr_pkg::SIZE_BITS-1:0]  screen_width,
   input  logic [lr_pkg::SIZE_BITS-1:0]  screen_height,
   input  logic                          down_take,
   output lr_pkg::pix_ctl_type           pix_ctl,
   output logic [COORD_BITS-1:0]         pix_x,
   output logic [COORD_BITS-1:0]         pix_y,
   output logic [lr_pkg::COLOR_BITS-1:0] pix_color
);
   import lr_pkg::*;

   localparam int LEN_BITS = COORD_BITS + 1;
   localparam int CMP_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

   // Clamp a coordinate to size minus one; a zero size pins it to zero.
   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [COORD_BITS-1:0] v,
                                                         input logic [SIZE_BITS-1:0] size);
      logic [CMP_BITS-1:0] v_wide;
      logic [CMP_BITS-1:0] size_wide;
      logic [CMP_BITS-1:0] top_wide;
      v_wide    = CMP_BITS'(v);
      size_wide = CMP_BITS'(size);
      top_wide  = size_wide - CMP_BITS'(1);
      if (v_wide < size_wide) begin
         return v;
      end else if (size == '0) begin
         return '0;
      end else begin
         return top_wide[COORD_BITS-1:0];
      end
   endfunction

   // One step along an axis, wrapping at the coordinate width.
   function automatic logic [COORD_BITS-1:0] move_coord(input logic [COORD_BITS-1:0] v,
                                                        input logic down);
      return down ? (v - COORD_BITS'(1)) : (v + COORD_BITS'(1));
   endfunction

   // Line state.
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic                  x_down_ff, y_down_ff, x_major_ff;
   logic [LEN_BITS-1:0]   err_ff, err_in;
   logic [LEN_BITS-1:0]   major_ff, minor_ff;
   logic [LEN_BITS-1:0]   left_ff, left_in;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  busy_ff, busy_in;

   // Pixel register toward the address stage.
   pix_ctl_type           ctl_ff, ctl_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [COLOR_BITS-1:0] pc_ff;

   // Setup and working values.
   logic                  fire, is_start, emit, step_minor;
   logic [COORD_BITS-1:0] x0, y0, x1, y1, diff_x, diff_y;
   logic [LEN_BITS-1:0]   dx, dy, esum;
   logic                  x_down_new, y_down_new, x_major_new;
   logic [COORD_BITS-1:0] b_x, b_y;
   logic                  b_x_down, b_y_down, b_x_major;
   logic [LEN_BITS-1:0]   b_err, b_major, b_minor, b_left;
   logic [COLOR_BITS-1:0] b_color;

   assign item_take = !ctl_ff.valid || down_take;
   assign fire      = item_valid && item_take;
   assign is_start  = (item_kind == KIND_START);
   assign emit      = is_start || busy_ff;

   // Start words: clamp endpoints, pick directions, lengths and the major axis.
   always_comb begin
      x0          = clamp_coord(start_x, screen_width);
      y0          = clamp_coord(start_y, screen_height);
      x1          = clamp_coord(end_x, screen_width);
      y1          = clamp_coord(end_y, screen_height);
      x_down_new  = (x1 < x0);
      y_down_new  = (y1 < y0);
      diff_x      = x_down_new ? (x0 - x1) : (x1 - x0);
      diff_y      = y_down_new ? (y0 - y1) : (y1 - y0);
      dx          = {1'b0, diff_x} + LEN_BITS'(1);
      dy          = {1'b0, diff_y} + LEN_BITS'(1);
      x_major_new = (dx >= dy);
   end

   // The pixel is taken either from fresh setup or from the stored line.
   always_comb begin
      if (is_start) begin
         b_x       = x0;
         b_y       = y0;
         b_x_down  = x_down_new;
         b_y_down  = y_down_new;
         b_x_major = x_major_new;
         b_err     = '0;
         b_major   = x_major_new ? dx : dy;
         b_minor   = x_major_new ? dy : dx;
         b_left    = x_major_new ? dx : dy;
         b_color   = line_color;
      end else begin
         b_x       = cur_x_ff;
         b_y       = cur_y_ff;
         b_x_down  = x_down_ff;
         b_y_down  = y_down_ff;
         b_x_major = x_major_ff;
         b_err     = err_ff;
         b_major   = major_ff;
         b_minor   = minor_ff;
         b_left    = left_ff;
         b_color   = color_ff;
      end
   end

   // Bresenham step: error update, minor step on overflow, major step always.
   always_comb begin
      left_in    = b_left - LEN_BITS'(1);
      busy_in    = (left_in != '0);
      esum       = b_err + b_minor;
      step_minor = (esum >= b_major);
      err_in     = step_minor ? (esum - b_major) : esum;
      cur_x_in   = b_x;
      cur_y_in   = b_y;
      if (b_x_major) begin
         cur_x_in = move_coord(b_x, b_x_down);
         if (step_minor) begin
            cur_y_in = move_coord(b_y, b_y_down);
         end
      end else begin
         cur_y_in = move_coord(b_y, b_y_down);
         if (step_minor) begin
            cur_x_in = move_coord(b_x, b_x_down);
         end
      end
      ctl_in.valid = fire && emit;
      ctl_in.last  = !busy_in;
   end

   // Line state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         x_down_ff  <= 1'b0;
         y_down_ff  <= 1'b0;
         x_major_ff <= 1'b0;
         err_ff     <= '0;
         major_ff   <= '0;
         minor_ff   <= '0;
         left_ff    <= '0;
         color_ff   <= '0;
         busy_ff    <= 1'b0;
      end else if (fire && emit) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         x_down_ff  <= b_x_down;
         y_down_ff  <= b_y_down;
         x_major_ff <= b_x_major;
         err_ff     <= err_in;
         major_ff   <= b_major;
         minor_ff   <= b_minor;
         left_ff    <= left_in;
         color_ff   <= b_color;
         busy_ff    <= busy_in;
      end
   end

   // Pixel register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (item_take) begin
         ctl_ff <= ctl_in;
      end
   end

   // Pixel register payload.
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         px_ff <= b_x;
         py_ff <= b_y;
         pc_ff <= b_color;
      end
   end

   assign pix_ctl   = ctl_ff;
   assign pix_x     = px_ff;
   assign pix_y     = py_ff;
   assign pix_color = pc_ff;

endmodule

[design/lr_addr.sv]
// Address pipeline: linear pixel index, then byte address and color, into the result register.
module lr_addr #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lr_pkg::pix_ctl_type           pix_ctl,
   input  logic [COORD_BITS-1:0]         pix_x,
   input  logic [COORD_BITS-1:0]         pix_y,
   input  logic [lr_pkg::COLOR_BITS-1:0] pix_color,
   output logic                          pix_take,
   input  logic [lr_pkg::SIZE_BITS-1:0]  screen_width,
   input  logic [lr_pkg::BPP_BITS-1:0]   bytes_per_pixel,
   input  logic [lr_pkg::ADDR_BITS-1:0]  buffer_base,
   lr_rsp_if.source                      rsp_chan
);
   import lr_pkg::*;

   localparam int LIN_BITS = COORD_BITS + SIZE_BITS + 1;

   // Index stage.
   pix_ctl_type           lin_ctl_ff;
   logic [LIN_BITS-1:0]   lin_ff, lin_in;
   logic [COORD_BITS-1:0] lx_ff, ly_ff;
   logic [COLOR_BITS-1:0] lc_ff;

   // Result register.
   pix_ctl_type           out_ctl_ff;
   logic [COORD_BITS-1:0] ox_ff, oy_ff;
   logic [ADDR_BITS-1:0]  oaddr_ff, oaddr_in;
   logic [COLOR_BITS-1:0] ocolor_ff, ocolor_in;

   logic                  adv_out, adv_lin, three_mode;
   logic [ADDR_BITS-1:0]  lin_word;

   assign adv_out  = !out_ctl_ff.valid || rsp_chan.ready;
   assign adv_lin  = !lin_ctl_ff.valid || adv_out;
   assign pix_take = adv_lin;

   // Row times width plus column.
   assign lin_in = LIN_BITS'(pix_y) * LIN_BITS'(screen_width) + LIN_BITS'(pix_x);

   // Scale by three in 3-byte mode and by four otherwise, add the base, and cut the color in 3-byte mode.
   always_comb begin
      three_mode = (bytes_per_pixel == BPP_THREE);
      lin_word   = ADDR_BITS'(lin_ff);
      if (three_mode) begin
         oaddr_in  = buffer_base + (lin_word << 1) + lin_word;
         ocolor_in = lc_ff & COLOR_24_MASK;
      end else begin
         oaddr_in  = buffer_base + (lin_word << 2);
         ocolor_in = lc_ff;
      end
   end

   // Stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ctl_ff <= '0;
         out_ctl_ff <= '0;
      end else begin
         if (adv_lin) begin
            lin_ctl_ff <= pix_ctl;
         end
         if (adv_out) begin
            out_ctl_ff <= lin_ctl_ff;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (adv_lin && pix_ctl.valid) begin
         lin_ff <= lin_in;
         lx_ff  <= pix_x;
         ly_ff  <= pix_y;
         lc_ff  <= pix_color;
      end
      if (adv_out && lin_ctl_ff.valid) begin
         ox_ff     <= lx_ff;
         oy_ff     <= ly_ff;
         oaddr_ff  <= oaddr_in;
         ocolor_ff <= ocolor_in;
      end
   end

   assign rsp_chan.valid         = out_ctl_ff.valid;
   assign rsp_chan.last          = out_ctl_ff.last;
   assign rsp_chan.pixel_x       = ox_ff;
   assign rsp_chan.pixel_y       = oy_ff;
   assign rsp_chan.pixel_address = oaddr_ff;
   assign rsp_chan.pixel_color   = ocolor_ff;

endmodule

[design/line_rasterizer.sv]
// Top level of the line rasterizer: registers, input register and the pixel pipeline.
//
//   Channel   Dir  Word
//   req_chan  in   kind, start_x, start_y, end_x, end_y, line_color
//   rsp_chan  out  pixel_x, pixel_y, pixel_address, pixel_color, last
//   csr_chan  in   index, data (screen_width, screen_height, bytes_per_pixel, buffer_base)
//
// One word is accepted per cycle while req_chan.ready is high.
// The stages are the input register, the stepping register, the row-times-width multiply
// and the result register.
// Reset clears the registers to their defaults and leaves the block idle.
// A stalled result holds every stage; req_chan.ready falls only once all stages are full.
module line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic     clock,
   input  logic     reset,
   lr_req_if.sink   req_chan,
   lr_rsp_if.source rsp_chan,
   lr_csr_if.sink   csr_chan
);
   import lr_pkg::*;

   // Configuration registers.
   logic [SIZE_BITS-1:0]  width_ff, height_ff;
   logic [BPP_BITS-1:0]   bpp_ff;
   logic [ADDR_BITS-1:0]  base_ff;

   // Input register.
   logic                  in_v_ff;
   logic                  in_kind_ff;
   logic [COORD_BITS-1:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;
   logic [COLOR_BITS-1:0] in_color_ff;

   logic                  step_take, addr_take;
   pix_ctl_type           step_ctl;
   logic [COORD_BITS-1:0] step_x, step_y;
   logic [COLOR_BITS-1:0] step_color;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !in_v_ff || step_take;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bpp_ff    <= BPP_RESET;
         base_ff   <= BASE_RESET;
      end else if (csr_chan.valid) begin
         case (csr_idx_type'(csr_chan.index))
            CSR_SCREEN_WIDTH:    width_ff  <= csr_chan.data[SIZE_BITS-1:0];
            CSR_SCREEN_HEIGHT:   height_ff <= csr_chan.data[SIZE_BITS-1:0];
            CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_chan.data[BPP_BITS-1:0];
            CSR_BUFFER_BASE:     base_ff   <= csr_chan.data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_v_ff <= req_chan.valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_kind_ff  <= req_chan.kind;
         in_sx_ff    <= req_chan.start_x;
         in_sy_ff    <= req_chan.start_y;
         in_ex_ff    <= req_chan.end_x;
         in_ey_ff    <= req_chan.end_y;
         in_color_ff <= req_chan.line_color;
      end
   end

   lr_step #(.COORD_BITS(COORD_BITS)) u_step (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (in_v_ff),
      .item_take     (step_take),
      .item_kind     (in_kind_ff),
      .start_x       (in_sx_ff),
      .start_y       (in_sy_ff),
      .end_x         (in_ex_ff),
      .end_y         (in_ey_ff),
      .line_color    (in_color_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .down_take     (addr_take),
      .pix_ctl       (step_ctl),
      .pix_x         (step_x),
      .pix_y         (step_y),
      .pix_color     (step_color)
   );

   lr_addr #(.COORD_BITS(COORD_BITS)) u_addr (
      .clock           (clock),
      .reset           (reset),
      .pix_ctl         (step_ctl),
      .pix_x           (step_x),
      .pix_y           (step_y),
      .pix_color       (step_color),
      .pix_take        (addr_take),
      .screen_width    (width_ff),
      .bytes_per_pixel (bpp_ff),
      .buffer_base     (base_ff),
      .rsp_chan        (rsp_chan)
   );

`ifndef ASSERT_OFF
   // A start word always yields a pixel in the stepping register.
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && step_take && in_kind_ff == KIND_START) |=> step_ctl.valid)
      else $error("start word produced no pixel");

   // A pixel blocked by the address stage keeps its contents.
   a_step_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ctl.valid && !addr_take) |=>
         (step_ctl.valid && $stable(step_x) && $stable(step_y) &&
          $stable(step_color) && $stable(step_ctl.last)))
      else $error("stepping register changed while stalled");

   // A buffered word waiting on the stepper is not lost, and its kind, start_x and end_y are not altered.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && !step_take) |=>
         (in_v_ff && $stable(in_kind_ff) && $stable(in_sx_ff) && $stable(in_ey_ff)))
      else $error("input register changed while stalled");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the line rasterizer: directed lines, register extremes, random traffic.
module tb;
   import lr_pkg::*;

   localparam int CB          = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 8;

   // One request word as the sender sees it.
   typedef struct {
      kind_type        kind;
      logic [CB-1:0]   sx;
      logic [CB-1:0]   sy;
      logic [CB-1:0]   ex;
      logic [CB-1:0]   ey;
      logic [31:0]     color;
   } draw_cmd_type;

   // One pixel word as the block should emit it.
   typedef struct {
      logic [CB-1:0]   x;
      logic [CB-1:0]   y;
      logic [31:0]     addr;
      logic [31:0]     color;
      logic            last;
   } pixel_word_type;

   logic clock;
   logic reset;

   lr_req_if #(.COORD_BITS(CB)) req ();
   lr_rsp_if #(.COORD_BITS(CB)) rsp ();
   lr_csr_if                    csr ();

   line_rasterizer #(.COORD_BITS(CB)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Register copies used by the pixel predictor.
   logic [SIZE_BITS-1:0] scr_w;
   logic [SIZE_BITS-1:0] scr_h;
   logic [BPP_BITS-1:0]  pix_bytes;
   logic [31:0]          fb_base;

   // Line walker state of the predictor.
   logic [CB-1:0]        pen_x, pen_y;
   bit                   x_back, y_back, x_major, drawing;
   logic [CB:0]          err_acc, major_n, minor_n, remaining;
   logic [31:0]          ink;

   pixel_word_type pending_pixels[$];

   int  errors;
   int  cycles;
   int  words_counted;
   int  pixels_checked;
   int  reg_writes;
   bit  jitter_on;
   int  hold_left;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run-time guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (!jitter_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Clamp one coordinate to the screen size minus one.
   function automatic logic [CB-1:0] clamp_coord(logic [CB-1:0] v, logic [SIZE_BITS-1:0] size);
      logic [SIZE_BITS-1:0] top;
      if ({1'b0, v} < size) return v;
      if (size == '0) return '0;
      top = size - 13'd1;
      return top[CB-1:0];
   endfunction

   function automatic logic [CB-1:0] nudge(logic [CB-1:0] v, bit down);
      return down ? v - 12'd1 : v + 12'd1;
   endfunction

   // Queue the pixel at the pen and walk the pen one step along the line.
   function automatic void emit_expected();
      pixel_word_type p;
      logic [31:0] bpp;
      bpp     = (pix_bytes == BPP_THREE) ? 32'd3 : 32'd4;
      p.x     = pen_x;
      p.y     = pen_y;
      p.addr  = fb_base + (32'(pen_y) * 32'(scr_w) + 32'(pen_x)) * bpp;
      p.color = (pix_bytes == BPP_THREE) ? (ink & COLOR_24_MASK) : ink;
      remaining = remaining - 13'd1;
      p.last  = (remaining == '0);
      pending_pixels.push_back(p);

      err_acc = err_acc + minor_n;
      if (err_acc >= major_n) begin
         err_acc = err_acc - major_n;
         if (x_major) pen_y = nudge(pen_y, y_back);
         else pen_x = nudge(pen_x, x_back);
      end
      if (x_major) pen_x = nudge(pen_x, x_back);
      else pen_y = nudge(pen_y, y_back);
      if (p.last) drawing = 1'b0;
   endfunction

   // Update the predictor for one accepted word; returns whether a pixel is due.
   function automatic bit predict_pixel(draw_cmd_type c);
      logic [CB-1:0] x0, y0, x1, y1;
      logic [CB:0]   dx, dy;
      if (c.kind == KIND_ADVANCE) begin
         if (!drawing) return 1'b0;
         emit_expected();
         return 1'b1;
      end
      x0 = clamp_coord(c.sx, scr_w);
      y0 = clamp_coord(c.sy, scr_h);
      x1 = clamp_coord(c.ex, scr_w);
      y1 = clamp_coord(c.ey, scr_h);
      x_back  = (x1 < x0);
      y_back  = (y1 < y0);
      dx      = (x_back ? 13'(x0) - 13'(x1) : 13'(x1) - 13'(x0)) + 13'd1;
      dy      = (y_back ? 13'(y0) - 13'(y1) : 13'(y1) - 13'(y0)) + 13'd1;
      x_major = (dx >= dy);
      major_n = x_major ? dx : dy;
      minor_n = x_major ? dy : dx;
      remaining = major_n;
      err_acc = '0;
      pen_x   = x0;
      pen_y   = y0;
      ink     = c.color;
      drawing = 1'b1;
      emit_expected();
      return 1'b1;
   endfunction

   function automatic void apply_reg(csr_idx_type idx, logic [31:0] value);
      case (idx)
         CSR_SCREEN_WIDTH:    scr_w = value[SIZE_BITS-1:0];
         CSR_SCREEN_HEIGHT:   scr_h = value[SIZE_BITS-1:0];
         CSR_BYTES_PER_PIXEL: pix_bytes = value[BPP_BITS-1:0];
         CSR_BUFFER_BASE:     fb_base = value;
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Pixel checker: every accepted word is held against the oldest expectation.
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel (%0d,%0d) arrived with nothing expected", rsp.pixel_x, rsp.pixel_y);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", 32'(want.x), 32'(rsp.pixel_x));
            check_field("pixel_y", 32'(want.y), 32'(rsp.pixel_y));
            check_field("pixel_address", want.addr, rsp.pixel_address);
            check_field("pixel_color", want.color, rsp.pixel_color);
            check_field("last", 32'(want.last), 32'(rsp.last));
            pixels_checked++;
         end
      end
   end

   // Result side: random stalls plus a long hold-off when a test asks for one.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   // Offer one word, wait for it to be taken and update the predictor.
   task automatic send_cmd(input draw_cmd_type c, output bit produced);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.kind       <= c.kind;
      req.start_x    <= c.sx;
      req.start_y    <= c.sy;
      req.end_x      <= c.ex;
      req.end_y      <= c.ey;
      req.line_color <= c.color;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      produced = predict_pixel(c);
      if (produced) words_counted++;
   endtask

   // Drop the request, wait for every pixel and let the pipeline settle.
   task automatic quiesce();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      apply_reg(idx, value);
      reg_writes++;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic set_screen(input int w, input int h, input int bpp, input logic [31:0] base);
      quiesce();
      write_reg(CSR_SCREEN_WIDTH, 32'(w));
      write_reg(CSR_SCREEN_HEIGHT, 32'(h));
      write_reg(CSR_BYTES_PER_PIXEL, 32'(bpp));
      write_reg(CSR_BUFFER_BASE, base);
   endtask

   function automatic draw_cmd_type random_cmd(kind_type kind);
      draw_cmd_type c;
      c.kind  = kind;
      c.sx    = CB'($urandom_range(0, 4095));
      c.sy    = CB'($urandom_range(0, 4095));
      c.ex    = CB'($urandom_range(0, 4095));
      c.ey    = CB'($urandom_range(0, 4095));
      c.color = $urandom;
      return c;
   endfunction

   task automatic send_advances(input int n);
      draw_cmd_type c;
      bit produced;
      repeat (n) begin
         c = random_cmd(KIND_ADVANCE);
         send_cmd(c, produced);
      end
   endtask

   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [31:0] color, input int advances);
      draw_cmd_type c;
      bit produced;
      c       = random_cmd(KIND_START);
      c.sx    = CB'(sx);
      c.sy    = CB'(sy);
      c.ex    = CB'(ex);
      c.ey    = CB'(ey);
      c.color = color;
      send_cmd(c, produced);
      send_advances(advances);
   endtask

   // Mostly on screen, sometimes anywhere in the coordinate range.
   function automatic logic [CB-1:0] pick_coord(logic [SIZE_BITS-1:0] size);
      int lim;
      if (size == '0 || $urandom_range(0, 9) < 3) return CB'($urandom_range(0, 4095));
      lim = (size > 13'd4096) ? 4096 : int'(size);
      return CB'($urandom_range(0, lim - 1));
   endfunction

   // Endpoints are usually close to the start so lines stay short.
   function automatic logic [CB-1:0] pick_end(logic [CB-1:0] s, logic [SIZE_BITS-1:0] size);
      int d;
      if ($urandom_range(0, 99) < 55) begin
         d = $urandom_range(0, 24);
         return 12'(int'(s) + d - 12);
      end
      return pick_coord(size);
   endfunction

   // An advance before any line has been started is ignored.
   task automatic test_idle_advance();
      send_advances(1);
   endtask

   // A coordinate beyond the reset screen width clamps to its last column.
   task automatic test_clamp_at_reset_size();
      draw_line(4095, 0, 637, 2, 32'hFFFF_FFFF, 2);
   endtask

   // Steep, flat and diagonal lines, a restart in mid-line and a single pixel.
   task automatic test_line_shapes();
      draw_line(10, 20, 11, 17, 32'h1234_5678, 3);
      draw_line(0, 0, 2, 0, 32'h0000_0000, 2);
      draw_line(5, 5, 9, 9, 32'hA5A5_5A5A, 1);
      draw_line(0, 0, 0, 0, 32'h0000_0000, 0);
      send_advances(1);
   endtask

   // Zero screen size, a screen as large as the coordinate range, odd pixel sizes and addresses that wrap.
   task automatic test_register_extremes();
      set_screen(0, 0, 7, 32'hFFFF_FFFC);
      draw_line(100, 200, 5, 5, 32'hDEAD_BEEF, 0);
      set_screen(4096, 4096, int'(BPP_THREE), 32'hFFFF_FFF0);
      draw_line(4095, 4095, 4094, 4095, 32'hFFFF_FFFF, 1);
      set_screen(1, 1, 0, 32'h0);
      draw_line(4095, 0, 0, 4095, 32'h8000_0001, 0);
   endtask

   // Base and pixel size change while a line is half drawn.
   task automatic test_mid_line_registers();
      set_screen(640, 480, 4, 32'h0);
      draw_line(0, 0, 3, 7, 32'h00C0_FFEE, 2);
      quiesce();
      write_reg(CSR_BUFFER_BASE, 32'h0010_0000);
      write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_THREE));
      send_advances(5);
   endtask

   // The result side holds off long enough for the block to fill and stop taking words.
   task automatic test_output_hold_off();
      set_screen(640, 480, 4, 32'h2000_0000);
      hold_left = 250;
      draw_line(10, 10, 40, 20, 32'h0F0F_F0F0, 30);
      quiesce();
   endtask

   // Random lines: mostly complete, some cut short, some with stray advances.
   task automatic run_random_lines(input int budget);
      draw_cmd_type c;
      bit produced;
      int done_items, adv, r;
      done_items = 0;
      while (done_items < budget) begin
         c = random_cmd(KIND_START);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            c.kind = KIND_ADVANCE;
            send_cmd(c, produced);
            if (produced) done_items++;
         end else begin
            c.sx = pick_coord(scr_w);
            c.sy = pick_coord(scr_h);
            c.ex = pick_end(c.sx, scr_w);
            c.ey = pick_end(c.sy, scr_h);
            send_cmd(c, produced);
            done_items++;
            adv = int'(remaining);
            r = $urandom_range(0, 99);
            if (r < 15) adv = $urandom_range(0, adv);
            else if (r < 25) adv = adv + $urandom_range(1, 3);
            if (adv > 48) adv = $urandom_range(20, 48);
            repeat (adv) begin
               c = random_cmd(KIND_ADVANCE);
               send_cmd(c, produced);
               if (produced) done_items++;
            end
         end
      end
   endtask

   task automatic test_random_lines();
      set_screen(640, 480, 4, 32'h1000_0000);
      run_random_lines(220);
      set_screen(4096, 4096, int'(BPP_THREE), 32'hFFFF_8000);
      run_random_lines(220);
      jitter_on = 1'b0;
      set_screen($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(0, 7),
                 $urandom);
      run_random_lines(200);
      jitter_on = 1'b1;
      set_screen(1, 1, 4, $urandom);
      run_random_lines(60);
      set_screen($urandom_range(1, 4096), $urandom_range(1, 4096), int'(BPP_THREE), $urandom);
      run_random_lines(250);
   endtask

   // Main sequence.
   initial begin
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.kind       = KIND_START;
      req.start_x    = '0;
      req.start_y    = '0;
      req.end_x      = '0;
      req.end_y      = '0;
      req.line_color = '0;
      rsp.ready      = 1'b0;
      csr.valid      = 1'b0;
      csr.index      = CSR_SCREEN_WIDTH;
      csr.data       = '0;

      scr_w     = WIDTH_RESET;
      scr_h     = HEIGHT_RESET;
      pix_bytes = BPP_RESET;
      fb_base   = BASE_RESET;
      pen_x     = '0;
      pen_y     = '0;
      x_back    = 1'b0;
      y_back    = 1'b0;
      x_major   = 1'b0;
      drawing   = 1'b0;
      err_acc   = '0;
      major_n   = '0;
      minor_n   = '0;
      remaining = '0;
      ink       = '0;
      jitter_on = 1'b1;
      hold_left = 0;

      // Reset starts high and is released on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_advance();
      test_clamp_at_reset_size();
      test_line_shapes();
      test_register_extremes();
      test_mid_line_registers();
      test_output_hold_off();
      test_random_lines();
      quiesce();

      $display("tb: %0d pixel-producing words sent, %0d pixels compared, %0d register writes",
               words_counted, pixels_checked, reg_writes);
      $display("tb: covered clamping, both step directions, restarts, odd pixel sizes, stalls");
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[sim.f]
design/lr_pkg.sv
design/lr_if.sv
design/lr_step.sv
design/lr_addr.sv
design/line_rasterizer.sv
tb/tb.sv
